>>> rtl/box_overlap_iou_macros.svh
// Assertion macros used by the box overlap checker.
// No dependencies; included by files that assert.
`ifndef BOX_OVERLAP_IOU_MACROS_SVH
`define BOX_OVERLAP_IOU_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BIOU_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BIOU_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/biou_pkg.sv
// Shared widths, register indexes and types for the box overlap block.
// No dependencies.
`default_nettype none

package biou_pkg;

    localparam int CW         = 12;           // coordinate width
    localparam int EW         = CW + 1;       // edge sum width
    localparam int AW         = 2 * CW;       // area width
    localparam int UW         = AW + 1;       // union width
    localparam int FRAC_BITS  = 16;
    localparam int OW         = FRAC_BITS + 1; // overlap width, holds 1.0
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (OW > CW) ? OW : CW;

    localparam logic [OW-1:0] THR_RESET = OW'(39322);   // 0.6
    localparam logic [OW-1:0] ONE_FX    = OW'(1 << FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] CFG_REF_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_W = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_H = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = CFG_IDX_W'(4);

    // Sideband that rides along the divider pipeline.
    typedef struct packed {
        logic last;
        logic zero;     // union was zero, force the result to 0
    } t_side;

endpackage

`default_nettype wire

>>> rtl/biou_box_if.sv
// Candidate box channel: valid/ready plus box fields.
// Depends on biou_pkg.
`default_nettype none

interface biou_box_if
    import biou_pkg::*;
;
    logic          valid;
    logic          ready;
    logic [CW-1:0] box_x;
    logic [CW-1:0] box_y;
    logic [CW-1:0] box_w;
    logic [CW-1:0] box_h;
    logic          last_box;

    modport source (output valid, input ready,
                    output box_x, output box_y, output box_w, output box_h,
                    output last_box);
    modport sink   (input valid, output ready,
                    input box_x, input box_y, input box_w, input box_h,
                    input last_box);
endinterface

`default_nettype wire

>>> rtl/biou_res_if.sv
// Result channel: valid/ready plus overlap, flag and last marker.
// Depends on biou_pkg.
`default_nettype none

interface biou_res_if
    import biou_pkg::*;
;
    logic          valid;
    logic          ready;
    logic [OW-1:0] overlap;
    logic          above_threshold;
    logic          last_result;

    modport source (output valid, input ready,
                    output overlap, output above_threshold, output last_result);
    modport sink   (input valid, output ready,
                    input overlap, input above_threshold, input last_result);
endinterface

`default_nettype wire

>>> rtl/biou_div.sv
// Pipelined restoring divider: one quotient bit per stage, OW stages.
// Gives floor((num << FRAC_BITS) / den) when num <= den. Depends on biou_pkg.
`default_nettype none

module biou_div
    import biou_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [AW-1:0] i_num,
    input  wire logic [UW-1:0] i_den,
    input  wire t_side         i_side,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [OW-1:0]      o_quo,
    output t_side              o_side
);

    logic          r_v    [OW];
    logic [OW-1:0] r_quo  [OW];
    t_side         r_side [OW];
    logic [UW-1:0] r_rem  [OW-1];
    logic [UW-1:0] r_den  [OW-1];
    logic          w_rdy  [OW+1];

    assign w_rdy[OW] = i_ready;
    assign o_ready   = w_rdy[0];
    assign o_valid   = r_v[OW-1];
    assign o_quo     = r_quo[OW-1];
    assign o_side    = r_side[OW-1];

    for (genvar k = 0; k < OW; k++) begin : g_stg
        logic [UW:0]   w_part;
        logic [UW:0]   w_dv;
        logic [UW:0]   w_diff;
        logic          w_ge;
        logic          w_vin;
        t_side         w_sin;
        logic [OW-1:0] w_qin;

        if (k == 0) begin : g_first
            // first step sees the numerator itself (top dividend bits)
            assign w_part = (UW+1)'(i_num);
            assign w_dv   = {1'b0, i_den};
            assign w_vin  = i_valid;
            assign w_sin  = i_side;
            assign w_qin  = '0;
        end else begin : g_next
            assign w_part = {r_rem[k-1], 1'b0};
            assign w_dv   = {1'b0, r_den[k-1]};
            assign w_vin  = r_v[k-1];
            assign w_sin  = r_side[k-1];
            assign w_qin  = r_quo[k-1];
        end

        assign w_ge     = (w_part >= w_dv);
        assign w_diff   = w_part - w_dv;
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_vin) begin
                r_quo[k]  <= {w_qin[OW-2:0], w_ge};
                r_side[k] <= w_sin;
            end
        end

        if (k < OW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_vin) begin
                    r_rem[k] <= w_ge ? w_diff[UW-1:0] : w_part[UW-1:0];
                    r_den[k] <= w_dv[UW-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/box_overlap_iou.sv
// Intersection-over-union of a candidate box against a configured reference box.
// Depends on biou_pkg, biou_box_if, biou_res_if and biou_div.
//
// Usage:
//   i_box carries one candidate box (x, y, w, h, last marker) per item; o_res
//   returns one item per box: overlap as unsigned Q1.16 in 17 bits (65536 = 1.0,
//   floor), a flag set when overlap is strictly above match_threshold, and
//   the last marker copied through. Both channels move an item on a rising
//   edge with valid and ready high.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data: 0 ref_x,
//   1 ref_y, 2 ref_w, 3 ref_h, 4 match_threshold. The user must write them
//   only while no item is in flight; the block does not enforce this.
//   Stages: 4 for edges, intersection, areas and union, 17 in the divider
//   (one quotient bit each), one output stage with the threshold compare.
//   Throughput: one item per clock while o_res takes results. Each stage has
//   its own valid bit and loads whenever it is empty or the stage after it
//   moves, so when o_res is stalled the pipeline keeps filling its empty slots
//   and only then drops i_box.ready; nothing is lost or repeated.
//   Reset (synchronous, active low) empties the pipeline, clears the
//   reference box to zero and sets the threshold to 0.6.
`default_nettype none

module box_overlap_iou
    import biou_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    biou_box_if.sink                   i_box,
    biou_res_if.source                 o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [CW-1:0] r_ref_x, r_ref_y, r_ref_w, r_ref_h;
    logic [OW-1:0] r_thr;
    logic [EW-1:0] r_ref_x2, r_ref_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_w <= '0;
            r_ref_h <= '0;
            r_thr   <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REF_X: r_ref_x <= i_cfg_data[CW-1:0];
                CFG_REF_Y: r_ref_y <= i_cfg_data[CW-1:0];
                CFG_REF_W: r_ref_w <= i_cfg_data[CW-1:0];
                CFG_REF_H: r_ref_h <= i_cfg_data[CW-1:0];
                CFG_THR:   r_thr   <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // reference edges, settled long before an item reaches stage 2
    always_ff @(posedge i_clk) begin
        r_ref_x2 <= EW'(r_ref_x) + EW'(r_ref_w);
        r_ref_y2 <= EW'(r_ref_y) + EW'(r_ref_h);
    end

    // handshake chain
    logic r1_v, r2_v, r3_v, r4_v, r_out_v;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy_out;
    logic w_div_in_rdy, w_div_v;

    assign w_rdy_out = !r_out_v || o_res.ready;
    assign w_rdy4    = !r4_v || w_div_in_rdy;
    assign w_rdy3    = !r3_v || w_rdy4;
    assign w_rdy2    = !r2_v || w_rdy3;
    assign w_rdy1    = !r1_v || w_rdy2;
    assign i_box.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_box.valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    // stage 1: candidate edges
    logic [CW-1:0] r1_cx, r1_cy, r1_cw, r1_ch;
    logic [EW-1:0] r1_cx2, r1_cy2;
    logic          r1_last;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_box.valid) begin
            r1_cx   <= i_box.box_x;
            r1_cy   <= i_box.box_y;
            r1_cw   <= i_box.box_w;
            r1_ch   <= i_box.box_h;
            r1_cx2  <= EW'(i_box.box_x) + EW'(i_box.box_w);
            r1_cy2  <= EW'(i_box.box_y) + EW'(i_box.box_h);
            r1_last <= i_box.last_box;
        end
    end

    // stage 2: intersection extents, zero when separated
    logic [EW-1:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y, w_dx, w_dy;
    logic          w_sep;
    logic [CW-1:0] r2_ix, r2_iy, r2_cw, r2_ch;
    logic          r2_last;

    always_comb begin
        w_sep  = (EW'(r1_cx) > r_ref_x2) || (EW'(r1_cy) > r_ref_y2) ||
                 (r1_cx2 < EW'(r_ref_x)) || (r1_cy2 < EW'(r_ref_y));
        w_lo_x = (r1_cx2 < r_ref_x2) ? r1_cx2 : r_ref_x2;
        w_hi_x = (r1_cx > r_ref_x) ? EW'(r1_cx) : EW'(r_ref_x);
        w_lo_y = (r1_cy2 < r_ref_y2) ? r1_cy2 : r_ref_y2;
        w_hi_y = (r1_cy > r_ref_y) ? EW'(r1_cy) : EW'(r_ref_y);
        w_dx   = w_lo_x - w_hi_x;
        w_dy   = w_lo_y - w_hi_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_v) begin
            // extent never exceeds either width, so CW bits hold it
            r2_ix   <= w_sep ? '0 : w_dx[CW-1:0];
            r2_iy   <= w_sep ? '0 : w_dy[CW-1:0];
            r2_cw   <= r1_cw;
            r2_ch   <= r1_ch;
            r2_last <= r1_last;
        end
    end

    // stage 3: areas
    logic [AW-1:0] r3_inter, r3_ac, r3_ar;
    logic          r3_last;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r2_v) begin
            r3_inter <= AW'(r2_ix) * AW'(r2_iy);
            r3_ac    <= AW'(r2_cw) * AW'(r2_ch);
            r3_ar    <= AW'(r_ref_w) * AW'(r_ref_h);
            r3_last  <= r2_last;
        end
    end

    // stage 4: union
    logic [UW-1:0] w_uni;
    logic [AW-1:0] r4_inter;
    logic [UW-1:0] r4_uni;
    t_side         r4_side;

    assign w_uni = UW'(r3_ac) + UW'(r3_ar) - UW'(r3_inter);

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r3_v) begin
            r4_inter     <= r3_inter;
            r4_uni       <= w_uni;
            r4_side.last <= r3_last;
            r4_side.zero <= (w_uni == '0);
        end
    end

    // divider
    logic [OW-1:0] w_quo;
    t_side         w_div_side;

    biou_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .o_ready (w_div_in_rdy),
        .i_num   (r4_inter),
        .i_den   (r4_uni),
        .i_side  (r4_side),
        .o_valid (w_div_v),
        .i_ready (w_rdy_out),
        .o_quo   (w_quo),
        .o_side  (w_div_side)
    );

    // output stage: zero-union override and threshold compare
    logic [OW-1:0] w_ov;
    logic [OW-1:0] r_ov;
    logic          r_flag, r_last;

    assign w_ov = w_div_side.zero ? '0 : w_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && w_div_v) begin
            r_ov   <= w_ov;
            r_flag <= (w_ov > r_thr);
            r_last <= w_div_side.last;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.overlap         = r_ov;
    assign o_res.above_threshold = r_flag;
    assign o_res.last_result     = r_last;

endmodule

`default_nettype wire

>>> rtl/biou_chk.sv
// Port-level checker for box_overlap_iou, attached by bind below.
// Depends on biou_pkg and box_overlap_iou_macros.svh.
`default_nettype none

`include "box_overlap_iou_macros.svh"

module biou_chk
    import biou_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    input  wire logic [OW-1:0]         i_res_overlap,
    input  wire logic                  i_res_above,
    input  wire logic                  i_res_last
);

    // threshold as seen on the configuration port
    logic [OW-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we && (i_cfg_idx == CFG_THR)) begin
            r_thr <= i_cfg_data[OW-1:0];
        end
    end

    `BIOU_AST_IMP(a_ovl_range, i_clk, i_rst_n, i_res_valid, i_res_overlap <= ONE_FX, "overlap above 1.0")

    `BIOU_AST_IMP(a_flag_match, i_clk, i_rst_n, i_res_valid, i_res_above == (i_res_overlap > r_thr), "threshold flag disagrees with overlap")

    `BIOU_AST_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_overlap) && $stable(i_res_above) && $stable(i_res_last), "stalled result changed")

endmodule

bind box_overlap_iou biou_chk u_biou_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_data    (i_cfg_data),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_overlap (o_res.overlap),
    .i_res_above   (o_res.above_threshold),
    .i_res_last    (o_res.last_result)
);

`default_nettype wire
